// ----- hw/rtl/plsn_pkg.sv -----
// Shared types and constants for the premultiplied layer sum block.
package plsn_pkg;

  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 16;
  localparam int SCALED_W    = SUM_W + CHAN_W;      // sum * 255
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 25;                  // ceil(2^32/255) fits in 25 bits
  localparam int PROD_W      = SCALED_W + RECIP_W;
  localparam int DIV_STEPS   = RECIP_SHIFT;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

  // Channel sums of one finished pixel position.
  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] alpha;
  } sums_t;

  // Saturating add of one 8-bit channel into a 16-bit sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                               input logic [CHAN_W-1:0] value);
    logic [SUM_W:0] total;
    total = {1'b0, sum} + {{(SUM_W + 1 - CHAN_W){1'b0}}, value};
    return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/plsn_front.sv -----
// Front end: accepts layer items and keeps the running channel sums.
module plsn_front import plsn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] in_blue,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_alpha,
  input  logic              last_layer,
  input  logic              q_full,
  output logic              push,
  output sums_t             push_data
);

  logic [SUM_W-1:0] blue_sum, green_sum, red_sum, alpha_sum;
  sums_t            sums_next;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    sums_next.blue  = sat_add(blue_sum, in_blue);
    sums_next.green = sat_add(green_sum, in_green);
    sums_next.red   = sat_add(red_sum, in_red);
    sums_next.alpha = sat_add(alpha_sum, in_alpha);
  end

  assign push      = accept && last_layer;
  assign push_data = sums_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      blue_sum  <= '0;
      green_sum <= '0;
      red_sum   <= '0;
      alpha_sum <= '0;
    end else if (accept) begin
      blue_sum  <= sums_next.blue;
      green_sum <= sums_next.green;
      red_sum   <= sums_next.red;
      alpha_sum <= sums_next.alpha;
    end
  end

endmodule

// ----- hw/rtl/plsn_queue.sv -----
// Short queue of finished pixel sums between front and back end.
module plsn_queue import plsn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  sums_t push_data,
  input  logic  pop,
  output logic  q_full,
  output logic  q_valid,
  output sums_t q_data
);

  sums_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/plsn_back.sv -----
// Back end: reciprocal divider, channel scaling and output register.
module plsn_back import plsn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sums_t             q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_alpha
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  logic [1:0]          state;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [1:0]          ch;
  logic [SUM_W-1:0]    denom;
  logic [SUM_W-1:0]    rem;
  logic [RECIP_W-1:0]  quo;
  logic [RECIP_W-1:0]  recip;
  logic [SCALED_W-1:0] scaled_b, scaled_g, scaled_r;
  logic [CHAN_W-1:0]   res_b, res_g, res_r, res_a;

  logic [SUM_W:0]      trial;
  logic                qbit;
  logic [SUM_W-1:0]    rem_next;
  logic [RECIP_W-1:0]  quo_next;
  logic [SCALED_W-1:0] mul_in;
  logic [PROD_W-1:0]   prod;
  logic                out_free;

  function automatic logic [SCALED_W-1:0] times255(input logic [SUM_W-1:0] s);
    return {s, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, s};
  endfunction

  assign pop      = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  // Restoring step on ceil(2^32/d) = floor((2^32-1)/d) + 1; dividend bits are all ones.
  always_comb begin
    trial = {rem, 1'b1};
    qbit  = (trial >= {1'b0, denom});
    rem_next = qbit ? SUM_W'(trial - {1'b0, denom}) : trial[SUM_W-1:0];
    quo_next = {quo[RECIP_W-2:0], qbit};
  end

  always_comb begin
    unique case (ch)
      CH_BLUE:  mul_in = scaled_b;
      CH_GREEN: mul_in = scaled_g;
      CH_RED:   mul_in = scaled_r;
      default:  mul_in = '0;
    endcase
    prod = PROD_W'(mul_in) * PROD_W'(recip);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      scaled_b <= times255(q_data.blue);
      scaled_g <= times255(q_data.green);
      scaled_r <= times255(q_data.red);
      res_a    <= (q_data.alpha > SUM_W'(CHAN_MAX)) ? CHAN_MAX : q_data.alpha[CHAN_W-1:0];
      denom    <= (q_data.alpha > SUM_W'(CHAN_MAX)) ? q_data.alpha : SUM_W'(CHAN_MAX);
      rem      <= '0;
      quo      <= '0;
    end else if (state == ST_DIV) begin
      rem <= rem_next;
      quo <= quo_next;
      if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        recip <= quo_next + 1'b1;
      end
    end
    if (state == ST_MUL) begin
      unique case (ch)
        CH_BLUE:  res_b <= prod[RECIP_SHIFT +: CHAN_W];
        CH_GREEN: res_g <= prod[RECIP_SHIFT +: CHAN_W];
        CH_RED:   res_r <= prod[RECIP_SHIFT +: CHAN_W];
        default:  ;
      endcase
    end
    if (state == ST_DONE && out_free) begin
      out_blue  <= res_b;
      out_green <= res_g;
      out_red   <= res_r;
      out_alpha <= res_a;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      ch        <= CH_BLUE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state   <= ST_DIV;
            div_cnt <= '0;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_MUL;
            ch    <= CH_BLUE;
          end
        end
        ST_MUL: begin
          ch <= ch + 1'b1;
          if (ch == CH_RED) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/premultiplied_layer_sum_normalize.sv -----
// Top level of the premultiplied layer sum and normalize block.
// Layer items of one pixel position arrive one per cycle; the front end adds each
// channel into a 16-bit sum that saturates at 65535 and accepts an item every cycle
// while the two-entry queue has room. The item flagged last_layer closes the position:
// its sums go into the queue and the running sums restart from zero. The back end
// takes one queued position at a time; it runs the 32-step bit-serial reciprocal
// divider (ceil(2^32 / max(alpha_sum, 255))), then passes each colour channel in
// turn through one shared 24x25 multiplier and loads the output register when it
// is free (not valid, or not stalled). in_stall is high exactly while the queue is
// full. A finished item waits in the output register while the back end goes on with
// the next queued position; out_alpha is the alpha sum clamped to 255 and each colour
// is the low 8 bits of floor(sum * 255 * recip / 2^32).
module premultiplied_layer_sum_normalize import plsn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] in_blue,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_alpha,
  input  logic              last_layer,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_alpha
);

  logic  push, pop, q_full, q_valid;
  sums_t push_data, q_data;

  // Accumulate and close positions
  plsn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_blue    (in_blue),
    .in_green   (in_green),
    .in_red     (in_red),
    .in_alpha   (in_alpha),
    .last_layer (last_layer),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Decouples the per-cycle front from the multi-cycle back end
  plsn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Reciprocal, scaling and output register
  plsn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .out_alpha (out_alpha)
  );

endmodule

// ----- hw/rtl/plsn_checker.sv -----
// Port-level checks for the premultiplied layer sum block, with bind.
module plsn_checker import plsn_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              last_layer,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAN_W-1:0] out_blue,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_alpha
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_blue) && $stable(out_green)
                               && $stable(out_red) && $stable(out_alpha))
    else $error("result changed while stalled");

  // Reset leaves nothing pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && !in_stall)
    else $error("state left after reset");

  // The input stalls only once a closing item has filled the queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall && last_layer))
    else $error("input stalled without a closing item");

endmodule

bind premultiplied_layer_sum_normalize plsn_checker u_plsn_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_layer (last_layer),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_blue   (out_blue),
  .out_green  (out_green),
  .out_red    (out_red),
  .out_alpha  (out_alpha)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the premultiplied layer sum and normalize block.
module tb_top;
  import plsn_pkg::*;

  // One layer item or one blended pixel: four 8-bit channels.
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE_WAIT  = 60;      // lets the back end finish its last position
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int PHASE_ITEMS  = 230;     // minimum layer items per random idling phase

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CHAN_W-1:0] in_blue = '0;
  logic [CHAN_W-1:0] in_green = '0;
  logic [CHAN_W-1:0] in_red = '0;
  logic [CHAN_W-1:0] in_alpha = '0;
  logic              last_layer = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_alpha;

  premultiplied_layer_sum_normalize dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_blue    (in_blue),
    .in_green   (in_green),
    .in_red     (in_red),
    .in_alpha   (in_alpha),
    .last_layer (last_layer),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .out_alpha  (out_alpha)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: running channel sums of the open pixel position.
  logic [SUM_W-1:0] acc_blue  = '0;
  logic [SUM_W-1:0] acc_green = '0;
  logic [SUM_W-1:0] acc_red   = '0;
  logic [SUM_W-1:0] acc_alpha = '0;

  pixel_t blended_pixels[$];   // blended pixels still owed by the block

  int send_idle_pct  = 0;      // chance in percent that the sender idles a cycle
  int recv_stall_pct = 0;      // chance in percent that the receiver stalls a cycle
  int hold_request   = 0;      // long hold-off asked of the receiver, in cycles
  int hold_left      = 0;

  int errors         = 0;
  int layers_sent    = 0;
  int pixels_checked = 0;
  int input_stalls   = 0;
  int sat_positions  = 0;
  int max_layers     = 0;
  int open_layers    = 0;

  // ---------------------------------------------------------------- predictor

  // 16-bit channel sum that sticks at all ones instead of wrapping.
  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] s,
                                                   input logic [CHAN_W-1:0] v);
    logic [SUM_W:0] wide;
    wide = {1'b0, s} + (SUM_W+1)'(v);
    if (wide > (SUM_W+1)'(SUM_MAX))
      return SUM_MAX;
    return wide[SUM_W-1:0];
  endfunction

  // floor(sum * 255 * recip / 2^32), low 8 bits only: colour above max(alpha, 255) wraps.
  function automatic logic [CHAN_W-1:0] scale_sum(input logic [SUM_W-1:0] s,
                                                  input logic [63:0] recip);
    logic [63:0] prod;
    prod = 64'(s) * 64'd255 * recip;
    return prod[RECIP_SHIFT +: CHAN_W];
  endfunction

  // Folds one accepted layer into the sums; on the closing layer the blended
  // pixel is queued and the sums restart from zero.
  function automatic void fold_layer(input pixel_t lay, input logic closing);
    logic [63:0] denom;
    logic [63:0] recip;
    pixel_t      px;
    acc_blue  = add_clamped(acc_blue,  lay.blue);
    acc_green = add_clamped(acc_green, lay.green);
    acc_red   = add_clamped(acc_red,   lay.red);
    acc_alpha = add_clamped(acc_alpha, lay.alpha);
    open_layers++;
    if (!closing)
      return;
    if (acc_alpha == SUM_MAX || acc_blue == SUM_MAX || acc_green == SUM_MAX ||
        acc_red == SUM_MAX)
      sat_positions++;
    if (open_layers > max_layers)
      max_layers = open_layers;
    // Reciprocal is ceil(2^32 / max(alpha_sum, 255)).
    denom = (acc_alpha > SUM_W'(CHAN_MAX)) ? 64'(acc_alpha) : 64'(CHAN_MAX);
    recip = ((64'd1 << RECIP_SHIFT) + denom - 64'd1) / denom;
    px.blue  = scale_sum(acc_blue,  recip);
    px.green = scale_sum(acc_green, recip);
    px.red   = scale_sum(acc_red,   recip);
    px.alpha = (acc_alpha > SUM_W'(CHAN_MAX)) ? CHAN_MAX : acc_alpha[CHAN_W-1:0];
    blended_pixels.push_back(px);
    acc_blue    = '0;
    acc_green   = '0;
    acc_red     = '0;
    acc_alpha   = '0;
    open_layers = 0;
  endfunction

  // ------------------------------------------------------------------ sender

  // Offers one layer item, starting at a falling edge, and returns at the
  // falling edge after it was taken. Valid stays high on return so that
  // back-to-back items never drop and re-raise valid in one step.
  task automatic send_layer(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] a,
                            input logic closing);
    pixel_t lay;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_blue    <= b;
    in_green   <= g;
    in_red     <= r;
    in_alpha   <= a;
    last_layer <= closing;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    lay = '{blue: b, green: g, red: r, alpha: a};
    fold_layer(lay, closing);
    layers_sent++;
    @(negedge clk);
  endtask

  // One pixel position of random layers. Well-formed layers keep colour at or
  // below alpha; noisy ones do not.
  task automatic send_position(input int layers, input bit noisy);
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
    for (int i = 0; i < layers; i++) begin
      case ($urandom_range(7))
        0: a = '0;
        1: a = CHAN_MAX;
        default: a = CHAN_W'($urandom_range(255));
      endcase
      if (noisy) begin
        b = CHAN_W'($urandom_range(255));
        g = CHAN_W'($urandom_range(255));
        r = CHAN_W'($urandom_range(255));
      end else begin
        b = CHAN_W'($urandom_range(a));
        g = CHAN_W'($urandom_range(a));
        r = CHAN_W'($urandom_range(a));
      end
      send_layer(b, g, r, a, i == layers - 1);
    end
  endtask

  // Parks the sender, waits for every owed pixel, then lets the back end go
  // quiet. Called at a falling edge with no drive pending in that step.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (blended_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  // Random stalls, or a long unbroken hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ----------------------------------------------------------------- checker

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    pixel_t got;
    if (!rst) begin
      if (in_valid && in_stall)
        input_stalls++;
      if (out_valid && !out_stall) begin
        got = '{blue: out_blue, green: out_green, red: out_red, alpha: out_alpha};
        if (blended_pixels.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("ERROR: unexpected pixel b=%0d g=%0d r=%0d a=%0d",
                     got.blue, got.green, got.red, got.alpha);
        end else begin
          want = blended_pixels.pop_front();
          pixels_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("ERROR: pixel %0d expected bgra %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       pixels_checked, want.blue, want.green, want.red, want.alpha,
                       got.blue, got.green, got.red, got.alpha);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------- tests

  // Hand-picked positions: channel extremes, single and multi layer, colour
  // above alpha, zero alpha.
  task automatic run_corner_pixels();
    send_layer(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);   // opaque white passes through
    send_layer(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);   // fully transparent
    send_layer(8'h80, 8'h40, 8'h01, 8'h80, 1'b1);   // single layer, half alpha
    send_layer(8'h55, 8'hAA, 8'h01, 8'hFE, 1'b1);
    send_layer(8'd100, 8'd50, 8'd0, 8'd100, 1'b0);  // two layers, alpha sum 255
    send_layer(8'd155, 8'd205, 8'd255, 8'd155, 1'b1);
    send_layer(8'd1, 8'd0, 8'd0, 8'd1, 1'b0);       // alpha sum 256
    send_layer(8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1);
    for (int i = 0; i < 3; i++)                     // alpha sum well above 255
      send_layer(8'd200, 8'd17, 8'd200, 8'd200, i == 2);
    send_layer(8'hFF, 8'hC8, 8'd11, 8'd10, 1'b1);   // colour above a small alpha comes out unchanged
    send_layer(8'h7F, 8'h01, 8'hFE, 8'h00, 1'b1);   // colour with zero alpha
    send_layer(8'h01, 8'h02, 8'h04, 8'h08, 1'b0);   // bit walk across layers
    send_layer(8'h10, 8'h20, 8'h40, 8'h80, 1'b0);
    send_layer(8'hEF, 8'hDF, 8'hBF, 8'h7F, 1'b1);
    drain_pixels();
  endtask

  // Deep stacks: exactly full sums, then stacks long enough to saturate.
  task automatic run_sum_saturation();
    for (int i = 0; i < 257; i++)                   // 257 * 255 = 65535, no clamp
      send_layer(8'hFF, 8'hFF, 8'hFF, 8'hFF, i == 256);
    for (int i = 0; i < 300; i++)                   // every sum clamps
      send_layer(8'hFF, 8'hFF, 8'hFF, 8'hFF, i == 299);
    for (int i = 0; i < 270; i++)                   // alpha and green clamp, blue and red do not
      send_layer(8'h80, 8'hFF, 8'h01, 8'hFF, i == 269);
    drain_pixels();
  endtask

  // Receiver holds off long enough for the block to fill and stall its input;
  // afterwards the sender waits for every pixel before going on.
  task automatic run_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    for (int i = 0; i < 30; i++)
      send_position($urandom_range(2, 1), 1'b0);
    drain_pixels();
    for (int i = 0; i < 4; i++) begin
      send_position($urandom_range(5, 1), 1'b0);
      drain_pixels();
    end
  endtask

  // Random positions, mostly short stacks of well-formed layers, some deep
  // stacks and some noise, under one idling setting.
  task automatic run_random_blend(input int idle_pct, input int stall_pct);
    int start;
    int layers;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = layers_sent;
    while (layers_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(11) == 0)
        layers = $urandom_range(40, 7);
      else
        layers = $urandom_range(6, 1);
      send_position(layers, $urandom_range(9) == 0);
    end
    drain_pixels();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_corner_pixels();
    run_sum_saturation();
    run_backpressure();
    run_random_blend(10, 67);
    run_random_blend(67, 10);
    run_random_blend(0, 0);
    if (blended_pixels.size() != 0) begin
      errors++;
      $display("ERROR: %0d pixels never came out", blended_pixels.size());
    end
    $display("Sent %0d layer items, checked %0d blended pixels (deepest stack %0d layers).",
             layers_sent, pixels_checked, max_layers);
    $display("Saturated positions: %0d, input stall cycles: %0d, mismatches: %0d.",
             sat_positions, input_stalls, errors);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- premultiplied_layer_sum_normalize.f -----
hw/rtl/plsn_pkg.sv
hw/rtl/plsn_front.sv
hw/rtl/plsn_queue.sv
hw/rtl/plsn_back.sv
hw/rtl/premultiplied_layer_sum_normalize.sv
hw/rtl/plsn_checker.sv
test/tb_top.sv
